/* design/ppts_pkg.sv */
// Shared types and constants for the perspective projection pipeline.
// Used by the front, back and top modules; depends on nothing.
package ppts_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FOCAL  = 3'd0,
    REG_ASPECT = 3'd1,
    REG_NEAR   = 3'd2,
    REG_FAR    = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_index_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 32;
  localparam int COORD_W    = 32;
  localparam int GAIN_W     = 31;
  localparam int DEPTH_W    = 32;
  localparam int DIV_W      = 32;
  localparam int DEPTH_K    = 31;
  localparam int DIV_STAGES = 16;

  // Sign and saturation flags that ride alongside the dividers.
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic d_neg;
    logic d_sat;
  } side_t;

endpackage

/* design/ppts_front.sv */
// Front end of the projection pipeline: magnitudes, focal scaling, depth product
// and divider setup over three register stages. Depends on ppts_pkg.
module ppts_front #(
  parameter int FRAC_BITS = 16,
  localparam int K = FRAC_BITS + 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [ppts_pkg::COORD_W-1:0] view_x,
  input  logic signed [ppts_pkg::COORD_W-1:0] view_y,
  input  logic signed [ppts_pkg::COORD_W-1:0] view_z,
  input  logic [ppts_pkg::GAIN_W-1:0]        focal_scale,
  input  logic [ppts_pkg::GAIN_W-1:0]        aspect_factor,
  input  logic signed [ppts_pkg::COORD_W-1:0] near_plane,
  input  logic signed [ppts_pkg::COORD_W-1:0] far_plane,
  output logic                               out_valid,
  output ppts_pkg::side_t                    side,
  output logic [ppts_pkg::DIV_W-1:0]         x_rem,
  output logic [K-1:0]                       x_lo,
  output logic [ppts_pkg::DIV_W-1:0]         x_div,
  output logic [ppts_pkg::DIV_W-1:0]         y_rem,
  output logic [K-1:0]                       y_lo,
  output logic [ppts_pkg::DIV_W-1:0]         y_div,
  output logic [ppts_pkg::DIV_W-1:0]         d_rem,
  output logic [ppts_pkg::DEPTH_K-1:0]       d_lo,
  output logic [ppts_pkg::DIV_W-1:0]         d_div
);

  localparam int PW = 63 - FRAC_BITS;
  localparam int ZMIN = (2 ** FRAC_BITS) / 10000 + 1;

  // Stage 1 registers.
  logic        v1;
  logic [31:0] ax1, ay1, az1, adz1, aden1, afar1;
  logic        sx1, sy1, sz1, sdz1, sden1, sfar1;
  logic [61:0] gprod1;

  // Stage 2 registers.
  logic          v2;
  logic [PW-1:0] apx2, apy2;
  logic [63:0]   num2;
  logic [31:0]   az2, aden2;
  logic          sx2, sy2, sz2, sden2, dneg2;

  logic signed [32:0] dz, den;
  logic [32:0]        dzm, denm;
  logic [61:0]        gsh;
  logic [30:0]        gain;
  logic [62:0]        px_full, py_full;
  logic [63:0]        num_full;

  logic          do_div, ovx, ovy, ovd;
  logic [PW-1:0] az4;
  logic [K-1:0]  bypx, bypy;

  always_comb begin
    dz   = {view_z[31], view_z} - {near_plane[31], near_plane};
    den  = {far_plane[31], far_plane} - {near_plane[31], near_plane};
    dzm  = dz[32] ? (~dz + 33'sd1) : dz;
    denm = den[32] ? (~den + 33'sd1) : den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1    <= view_x[31] ? (~view_x + 32'sd1) : view_x;
      ay1    <= view_y[31] ? (~view_y + 32'sd1) : view_y;
      az1    <= view_z[31] ? (~view_z + 32'sd1) : view_z;
      afar1  <= far_plane[31] ? (~far_plane + 32'sd1) : far_plane;
      adz1   <= dzm[31:0];
      aden1  <= denm[31:0];
      sx1    <= view_x[31];
      sy1    <= view_y[31];
      sz1    <= view_z[31];
      sfar1  <= far_plane[31];
      sdz1   <= dz[32];
      sden1  <= den[32];
      gprod1 <= 62'(focal_scale) * 62'(aspect_factor);
    end
  end

  // Stage 2: horizontal gain saturates to 31 bits, then one multiply per lane.
  always_comb begin
    gsh      = gprod1 >> FRAC_BITS;
    gain     = (|gsh[61:31]) ? 31'h7FFF_FFFF : gsh[30:0];
    px_full  = 63'(ax1) * 63'(gain);
    py_full  = 63'(ay1) * 63'(focal_scale);
    num_full = 64'(adz1) * 64'(afar1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      apx2  <= PW'(px_full >> FRAC_BITS);
      apy2  <= PW'(py_full >> FRAC_BITS);
      num2  <= num_full;
      az2   <= az1;
      aden2 <= aden1;
      sx2   <= sx1;
      sy2   <= sy1;
      sz2   <= sz1;
      sden2 <= sden1;
      dneg2 <= sdz1 ^ sfar1;
    end
  end

  // Stage 3: choose between a true divide and a divide by one that passes a
  // saturated magnitude through the same divider.
  always_comb begin
    do_div = az2 >= 32'(ZMIN);
    az4    = PW'({az2, 2'b00});
    ovx    = apx2 >= az4;
    ovy    = apy2 >= az4;
    bypx   = (|apx2[PW-1:K]) ? '1 : apx2[K-1:0];
    bypy   = (|apy2[PW-1:K]) ? '1 : apy2[K-1:0];
    ovd    = num2[62:0] >= {aden2, 31'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (do_div && !ovx) begin
        x_rem <= apx2[33:2];
        x_lo  <= {apx2[1:0], {FRAC_BITS{1'b0}}};
        x_div <= az2;
      end else begin
        x_rem <= '0;
        x_lo  <= do_div ? '1 : bypx;
        x_div <= 32'd1;
      end
      if (do_div && !ovy) begin
        y_rem <= apy2[33:2];
        y_lo  <= {apy2[1:0], {FRAC_BITS{1'b0}}};
        y_div <= az2;
      end else begin
        y_rem <= '0;
        y_lo  <= do_div ? '1 : bypy;
        y_div <= 32'd1;
      end
      if (ovd) begin
        d_rem <= '0;
        d_lo  <= '0;
        d_div <= 32'd1;
      end else begin
        d_rem <= num2[62:31];
        d_lo  <= num2[30:0];
        d_div <= aden2;
      end
      side.x_neg <= sx2 ^ (do_div & sz2);
      side.y_neg <= sy2 ^ (do_div & sz2);
      side.d_neg <= dneg2 ^ ((aden2 != 32'd0) & sden2);
      side.d_sat <= ovd & (|num2);
    end
  end

endmodule

/* design/ppts_div.sv */
// Pipelined restoring divider: a few quotient bits per register stage.
// The remainder entering must be below the divisor. Depends on nothing.
module ppts_div #(
  parameter int DW     = 32,
  parameter int K      = 18,
  parameter int STAGES = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_in,
  input  logic [K-1:0]  lo_in,
  input  logic [DW-1:0] div_in,
  output logic [K-1:0]  quo
);

  localparam int SPS = (K + STAGES - 1) / STAGES;

  logic [DW-1:0] rem_q [STAGES];
  logic [K-1:0]  lo_q  [STAGES];
  logic [K-1:0]  q_q   [STAGES];
  logic [DW-1:0] d_q   [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DW-1:0] rem_i, d_i, rem_n;
    logic [K-1:0]  lo_i, q_i, lo_n, q_n;

    if (s == 0) begin : g_first
      assign rem_i = rem_in;
      assign lo_i  = lo_in;
      assign q_i   = '0;
      assign d_i   = div_in;
    end else begin : g_next
      assign rem_i = rem_q[s-1];
      assign lo_i  = lo_q[s-1];
      assign q_i   = q_q[s-1];
      assign d_i   = d_q[s-1];
    end

    always_comb begin
      logic [DW:0] trial;
      rem_n = rem_i;
      lo_n  = lo_i;
      q_n   = q_i;
      trial = '0;
      for (int t = 0; t < SPS; t++) begin
        if (s * SPS + t < K) begin
          trial = {rem_n, lo_n[K-1]};
          lo_n  = lo_n << 1;
          if (trial >= {1'b0, d_i}) begin
            rem_n = DW'(trial - {1'b0, d_i});
            q_n   = {q_n[K-2:0], 1'b1};
          end else begin
            rem_n = trial[DW-1:0];
            q_n   = {q_n[K-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_n;
        lo_q[s]  <= lo_n;
        q_q[s]   <= q_n;
        d_q[s]   <= d_i;
      end
    end
  end

  assign quo = q_q[STAGES-1];

endmodule

/* design/ppts_back.sv */
// Back end of the projection pipeline: sign, offset, clamp and depth saturation,
// then the screen multiply with round half up. Depends on ppts_pkg.
module ppts_back #(
  parameter int FRAC_BITS   = 16,
  parameter int SCREEN_BITS = 13,
  localparam int K = FRAC_BITS + 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  ppts_pkg::side_t                    side,
  input  logic [K-1:0]                       qx,
  input  logic [K-1:0]                       qy,
  input  logic [ppts_pkg::DEPTH_K-1:0]       qd,
  input  logic [SCREEN_BITS-1:0]             screen_width,
  input  logic [SCREEN_BITS-1:0]             screen_height,
  output logic                               out_valid,
  output logic [SCREEN_BITS-1:0]             screen_x,
  output logic [SCREEN_BITS-1:0]             screen_y,
  output logic signed [ppts_pkg::DEPTH_W-1:0] depth_value
);

  localparam int NW  = FRAC_BITS + 2;
  localparam int PRW = FRAC_BITS + 3 + SCREEN_BITS;
  localparam logic signed [K+1:0] OneS = (K+2)'(2 ** FRAC_BITS);
  localparam logic signed [K+1:0] TwoS = (K+2)'(2 ** (FRAC_BITS + 1));

  logic signed [K+1:0] qxs, qys, nx, ny;
  logic [NW-1:0]       nxc, nyc;
  logic [31:0]         dm, dval;

  logic                v1;
  logic [NW-1:0]       nx1, ny1;
  logic [31:0]         d1;
  logic [PRW-1:0]      cx, cy;

  always_comb begin
    qxs = side.x_neg ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
    qys = side.y_neg ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
    nx  = qxs + OneS;
    ny  = OneS - qys;
    if (nx < 0) begin
      nxc = '0;
    end else if (nx > TwoS) begin
      nxc = NW'(TwoS);
    end else begin
      nxc = nx[NW-1:0];
    end
    if (ny < 0) begin
      nyc = '0;
    end else if (ny > TwoS) begin
      nyc = NW'(TwoS);
    end else begin
      nyc = ny[NW-1:0];
    end
    dm = {1'b0, qd};
    if (side.d_sat) begin
      dval = side.d_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      dval = side.d_neg ? (~dm + 32'd1) : dm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // Round half up: add one half cell before dropping the fraction.
  always_comb begin
    cx = PRW'(nx1) * PRW'(screen_width) + PRW'(OneS);
    cy = PRW'(ny1) * PRW'(screen_height) + PRW'(OneS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1         <= nxc;
      ny1         <= nyc;
      d1          <= dval;
      screen_x    <= SCREEN_BITS'(cx >> (FRAC_BITS + 1));
      screen_y    <= SCREEN_BITS'(cy >> (FRAC_BITS + 1));
      depth_value <= d1;
    end
  end

endmodule

/* design/perspective_project_to_screen.sv */
// Perspective projection and viewport mapping of view-space vertices.
// An input transfer passes through three front stages, 16 divider stages and
// two back stages. One vertex per cycle unless a result waits at the output.
// The whole pipeline advances unless a result waits at the output.
// Reset clears valid bits and loads the configuration defaults.
module perspective_project_to_screen #(
  parameter int FRAC_BITS   = 16,
  parameter int SCREEN_BITS = 13,
  localparam int OUT_W = ((2 * SCREEN_BITS + 32 + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // view_x [31:0], view_y [63:32], view_z [95:64]
  input  logic [95:0]                      s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // screen_x, screen_y, depth_value (lowest first), zero padded to bytes
  output logic [OUT_W-1:0]                 m_tdata,
  input  logic                             cfg_we,
  input  logic [ppts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppts_pkg::CFG_W-1:0]       cfg_data
);

  localparam int K  = FRAC_BITS + 2;
  localparam int NS = ppts_pkg::DIV_STAGES;

  // Configuration registers.
  logic [ppts_pkg::GAIN_W-1:0]         focal_scale, aspect_factor;
  logic signed [ppts_pkg::COORD_W-1:0] near_plane, far_plane;
  logic [SCREEN_BITS-1:0]              screen_width, screen_height;

  // Both gains come out of reset at 1.0 in the fixed-point format.
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_scale   <= 31'(2 ** FRAC_BITS);
      aspect_factor <= 31'(2 ** FRAC_BITS);
      near_plane    <= 32'sd6554;
      far_plane     <= 32'sd6553600;
      screen_width  <= SCREEN_BITS'(80);
      screen_height <= SCREEN_BITS'(25);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppts_pkg::REG_FOCAL:  focal_scale   <= cfg_data[30:0];
        ppts_pkg::REG_ASPECT: aspect_factor <= cfg_data[30:0];
        ppts_pkg::REG_NEAR:   near_plane    <= cfg_data;
        ppts_pkg::REG_FAR:    far_plane     <= cfg_data;
        ppts_pkg::REG_WIDTH:  screen_width  <= cfg_data[SCREEN_BITS-1:0];
        ppts_pkg::REG_HEIGHT: screen_height <= cfg_data[SCREEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // One enable for every stage: the pipeline moves whenever the output
  // register is empty or its result is taken in this cycle, so a stall
  // freezes every item in place and nothing is lost or repeated.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic                         f_valid;
  ppts_pkg::side_t              f_side;
  logic [ppts_pkg::DIV_W-1:0]   x_rem, x_div, y_rem, y_div, d_rem, d_div;
  logic [K-1:0]                 x_lo, y_lo, qx, qy;
  logic [ppts_pkg::DEPTH_K-1:0] d_lo, qd;

  ppts_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (s_tvalid),
    .view_x        (s_tdata[31:0]),
    .view_y        (s_tdata[63:32]),
    .view_z        (s_tdata[95:64]),
    .focal_scale   (focal_scale),
    .aspect_factor (aspect_factor),
    .near_plane    (near_plane),
    .far_plane     (far_plane),
    .out_valid     (f_valid),
    .side          (f_side),
    .x_rem         (x_rem),
    .x_lo          (x_lo),
    .x_div         (x_div),
    .y_rem         (y_rem),
    .y_lo          (y_lo),
    .y_div         (y_div),
    .d_rem         (d_rem),
    .d_lo          (d_lo),
    .d_div         (d_div)
  );

  // Three dividers of equal depth: x and y by |z|, depth by |far - near|.
  // Saturated cases enter as a divide by one so every lane keeps the timing.
  ppts_div #(.DW(ppts_pkg::DIV_W), .K(K), .STAGES(NS)) u_div_x (
    .clk (clk), .en (en), .rem_in (x_rem), .lo_in (x_lo), .div_in (x_div), .quo (qx)
  );

  ppts_div #(.DW(ppts_pkg::DIV_W), .K(K), .STAGES(NS)) u_div_y (
    .clk (clk), .en (en), .rem_in (y_rem), .lo_in (y_lo), .div_in (y_div), .quo (qy)
  );

  ppts_div #(.DW(ppts_pkg::DIV_W), .K(ppts_pkg::DEPTH_K), .STAGES(NS)) u_div_d (
    .clk (clk), .en (en), .rem_in (d_rem), .lo_in (d_lo), .div_in (d_div), .quo (qd)
  );

  // Valid bits and sign and saturation flags travel beside the divider stages.
  logic            vd [NS];
  ppts_pkg::side_t sd [NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        vd[i] <= 1'b0;
      end
    end else if (en) begin
      vd[0] <= f_valid;
      for (int i = 1; i < NS; i++) begin
        vd[i] <= vd[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= f_side;
      for (int i = 1; i < NS; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  logic [SCREEN_BITS-1:0]              screen_x, screen_y;
  logic signed [ppts_pkg::DEPTH_W-1:0] depth_value;

  ppts_back #(.FRAC_BITS(FRAC_BITS), .SCREEN_BITS(SCREEN_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (vd[NS-1]),
    .side          (sd[NS-1]),
    .qx            (qx),
    .qy            (qy),
    .qd            (qd),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_valid     (m_tvalid),
    .screen_x      (screen_x),
    .screen_y      (screen_y),
    .depth_value   (depth_value)
  );

  assign m_tdata = OUT_W'({depth_value, screen_y, screen_x});

endmodule
